// ===== hw/rtl/pps_pkg.sv =====
`timescale 1ns / 1ps

package pps_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned ID_WIDTH_DEF    = 8;

  // Priority levels: 0 highest, 2 lowest
  localparam int unsigned LEVELS = 3;
  localparam int unsigned LVL_W  = 2;

  localparam logic       OP_ARRIVAL   = 1'b0;
  localparam logic       OP_COMPLETE  = 1'b1;
  localparam logic [1:0] PRIO_INVALID = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic latch;  // capture the input transfer
    logic exec;   // make the scheduling decision, issue memory accesses
    logic load;   // pick up registered memory read data
  } pps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_pending;  // the decision issued a memory read
  } pps_stat_t;

endpackage

// ===== hw/rtl/pps_ram.sv =====
`timescale 1ns / 1ps

module pps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pps_ctrl.sv =====
`timescale 1ns / 1ps

module pps_ctrl
  import pps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output pps_cmd_t  cmd,
  input  pps_stat_t stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    cmd.latch = (state_r == ST_IDLE) && in_valid;
    cmd.exec  = (state_r == ST_EXEC);
    cmd.load  = (state_r == ST_LOAD);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = stat.load_pending ? ST_LOAD : ST_OUT;
      end
      ST_LOAD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/pps_dp.sv =====
`timescale 1ns / 1ps

module pps_dp
  import pps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pps_cmd_t            cmd,
  output pps_stat_t           stat,
  input  logic                in_opcode,
  input  logic [1:0]          in_task_priority,
  input  logic [ID_WIDTH-1:0] in_task_id,
  output logic                res_running_valid,
  output logic [ID_WIDTH-1:0] res_running_id,
  output logic [1:0]          res_running_priority,
  output logic                res_resumed,
  output logic                res_preempted,
  output logic                res_overflow
);

  localparam int unsigned QAW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUMW = QCW + 1;
  localparam int unsigned SAW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SDW  = ID_WIDTH + 2;

  // Captured input transfer
  logic                op_r;
  logic [1:0]          prio_r;
  logic [ID_WIDTH-1:0] id_r;

  // Queue pointers and fill counts
  logic [QAW-1:0] head_r   [LEVELS];
  logic [QAW-1:0] head_nxt [LEVELS];
  logic [QAW-1:0] head_inc [LEVELS];
  logic [QCW-1:0] cnt_r    [LEVELS];
  logic [QCW-1:0] cnt_nxt  [LEVELS];

  logic [SPW-1:0] sp_r;
  logic [SPW-1:0] sp_nxt;
  logic [SPW-1:0] sp_dec;

  // Running task
  logic [ID_WIDTH-1:0] cur_id_r;
  logic [ID_WIDTH-1:0] cur_id_nxt;
  logic [1:0]          cur_prio_r;
  logic [1:0]          cur_prio_nxt;
  logic                cur_valid_r;
  logic                cur_valid_nxt;
  logic                from_stack_r;
  logic                from_stack_nxt;
  logic                preempt_r;
  logic                preempt_nxt;
  logic                ovf_r;
  logic                ovf_nxt;

  // Where the pending read comes from
  logic             ld_stack_r;
  logic             ld_stack_nxt;
  logic [LVL_W-1:0] ld_lvl_r;
  logic [LVL_W-1:0] ld_lvl_nxt;

  // Memory ports
  logic [LEVELS-1:0]   q_we;
  logic [LEVELS-1:0]   q_re;
  logic [QAW-1:0]      q_waddr;
  logic [ID_WIDTH-1:0] q_rdata [LEVELS];
  logic                s_we;
  logic                s_re;
  logic [SDW-1:0]      s_rdata;

  logic [LVL_W-1:0] lvl_a;
  logic [SUMW-1:0]  tail_sum;
  logic             found;
  logic [LVL_W-1:0] sel;

  // Arrival level, folded to a legal index for the invalid code
  assign lvl_a  = (prio_r == PRIO_INVALID) ? '0 : prio_r;
  assign sp_dec = sp_r - SPW'(1);

  always_comb begin
    tail_sum = SUMW'(head_r[lvl_a]) + SUMW'(cnt_r[lvl_a]);
    if (tail_sum >= SUMW'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUMW'(QUEUE_DEPTH);
    end
    q_waddr = tail_sum[QAW-1:0];
  end

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      head_inc[l] = (head_r[l] == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r[l] + QAW'(1);
    end
  end

  // Highest non-empty queue
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        found = 1'b1;
        sel   = LVL_W'(l);
      end
    end
  end

  always_comb begin
    head_nxt          = head_r;
    cnt_nxt           = cnt_r;
    sp_nxt            = sp_r;
    cur_id_nxt        = cur_id_r;
    cur_prio_nxt      = cur_prio_r;
    cur_valid_nxt     = cur_valid_r;
    from_stack_nxt    = from_stack_r;
    preempt_nxt       = preempt_r;
    ovf_nxt           = ovf_r;
    ld_stack_nxt      = ld_stack_r;
    ld_lvl_nxt        = ld_lvl_r;
    q_we              = '0;
    q_re              = '0;
    s_we              = 1'b0;
    s_re              = 1'b0;
    stat.load_pending = 1'b0;

    if (cmd.exec) begin
      preempt_nxt = 1'b0;
      ovf_nxt     = 1'b0;
      if (op_r == OP_ARRIVAL) begin
        if (prio_r != PRIO_INVALID) begin
          if (cnt_r[lvl_a] == QCW'(QUEUE_DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            q_we[lvl_a]    = 1'b1;
            cnt_nxt[lvl_a] = cnt_r[lvl_a] + QCW'(1);
            if (!from_stack_r && (!cur_valid_r ||
                (cur_prio_r > prio_r && sp_r != SPW'(STACK_DEPTH)))) begin
              if (cur_valid_r) begin
                s_we        = 1'b1;
                sp_nxt      = sp_r + SPW'(1);
                preempt_nxt = 1'b1;
              end
              // Take the head straight back out: net count unchanged
              cur_prio_nxt    = prio_r;
              cur_valid_nxt   = 1'b1;
              from_stack_nxt  = 1'b0;
              head_nxt[lvl_a] = head_inc[lvl_a];
              cnt_nxt[lvl_a]  = cnt_r[lvl_a];
              if (cnt_r[lvl_a] == '0) begin
                cur_id_nxt = id_r;
              end else begin
                q_re[lvl_a]       = 1'b1;
                stat.load_pending = 1'b1;
                ld_stack_nxt      = 1'b0;
                ld_lvl_nxt        = lvl_a;
              end
            end
          end
        end
      end else if (cur_valid_r) begin
        if (found) begin
          q_re[sel]         = 1'b1;
          head_nxt[sel]     = head_inc[sel];
          cnt_nxt[sel]      = cnt_r[sel] - QCW'(1);
          cur_prio_nxt      = sel;
          from_stack_nxt    = 1'b0;
          stat.load_pending = 1'b1;
          ld_stack_nxt      = 1'b0;
          ld_lvl_nxt        = sel;
        end else if (sp_r != '0) begin
          sp_nxt            = sp_dec;
          s_re              = 1'b1;
          from_stack_nxt    = 1'b1;
          stat.load_pending = 1'b1;
          ld_stack_nxt      = 1'b1;
        end else begin
          cur_valid_nxt  = 1'b0;
          from_stack_nxt = 1'b0;
        end
      end
    end

    if (cmd.load) begin
      if (ld_stack_r) begin
        cur_id_nxt   = s_rdata[ID_WIDTH-1:0];
        cur_prio_nxt = s_rdata[SDW-1:ID_WIDTH];
      end else begin
        cur_id_nxt = q_rdata[ld_lvl_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_opcode;
      prio_r <= in_task_priority;
      id_r   <= in_task_id;
    end
    ld_lvl_r   <= ld_lvl_nxt;
    ld_stack_r <= ld_stack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
      sp_r         <= '0;
      cur_id_r     <= '0;
      cur_prio_r   <= '0;
      cur_valid_r  <= 1'b0;
      from_stack_r <= 1'b0;
      preempt_r    <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      cnt_r        <= cnt_nxt;
      sp_r         <= sp_nxt;
      cur_id_r     <= cur_id_nxt;
      cur_prio_r   <= cur_prio_nxt;
      cur_valid_r  <= cur_valid_nxt;
      from_stack_r <= from_stack_nxt;
      preempt_r    <= preempt_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  for (genvar g = 0; g < LEVELS; g++) begin : g_queue
    pps_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
      .clk   (clk),
      .we    (q_we[g]),
      .waddr (q_waddr),
      .wdata (id_r),
      .re    (q_re[g]),
      .raddr (head_r[g]),
      .rdata (q_rdata[g])
    );
  end

  pps_ram #(
    .WIDTH (SDW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (sp_r[SAW-1:0]),
    .wdata ({cur_prio_r, cur_id_r}),
    .re    (s_re),
    .raddr (sp_dec[SAW-1:0]),
    .rdata (s_rdata)
  );

  // Idle reads as all zero
  assign res_running_valid    = cur_valid_r;
  assign res_running_id       = cur_valid_r ? cur_id_r : '0;
  assign res_running_priority = cur_valid_r ? cur_prio_r : '0;
  assign res_resumed          = cur_valid_r && from_stack_r;
  assign res_preempted        = preempt_r;
  assign res_overflow         = ovf_r;

endmodule

// ===== hw/rtl/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// Sequence: after the input transfer the decision is made (EXEC), then out_valid
//   rises (OUT); a LOAD step comes between when the decision reads a task id back
//   from a queue or the preemption stack (registered RAM read). Events are taken
//   one at a time; a new one is taken the cycle after the result transfer.
// Reset (rst_n, synchronous, active low): queues and stack empty, processor idle.
//   Queue and stack RAM contents are not cleared; only written entries are read.

module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Event input: arrival or completion
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic [1:0]          in_task_priority,
  input  logic [ID_WIDTH-1:0] in_task_id,
  // Scheduling result, one per event
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_running_valid,
  output logic [ID_WIDTH-1:0] out_running_id,
  output logic [1:0]          out_running_priority,
  output logic                out_resumed,
  output logic                out_preempted,
  output logic                out_overflow
);

  pps_cmd_t  cmd;
  pps_stat_t stat;

  // Sequencer: accept a transfer, decide, optionally pick up RAM data, then
  // hold the result until the downstream side takes it.
  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: the three FIFO queues, the preemption stack and the running task.
  // Result fields come straight from the running-task registers, which do not
  // change while a result waits, so the payload holds under stall.
  pps_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .STACK_DEPTH (STACK_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_opcode            (in_opcode),
    .in_task_priority     (in_task_priority),
    .in_task_id           (in_task_id),
    .res_running_valid    (out_running_valid),
    .res_running_id       (out_running_id),
    .res_running_priority (out_running_priority),
    .res_resumed          (out_resumed),
    .res_preempted        (out_preempted),
    .res_overflow         (out_overflow)
  );

endmodule
